// ----- design/chebpe_pkg.sv -----
package chebpe_pkg;

    // Fixed-point format and sizing.
    localparam int FRAC_BITS  = 16;
    localparam int MAX_DEGREE = 32;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 32;
    localparam int DEG_W    = 6;
    localparam int VAL_W    = 48;
    localparam int HALF_W   = VAL_W / 2;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int CNT_W    = $clog2(MAX_DEGREE + 1);
    localparam int ADDR_W   = 4;
    localparam int IDX_W    = 2;

    // Saturation limits and the constant 1.0 in the value format.
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRAC_BITS;

    // Register reset values.
    localparam logic [CFG_W-1:0] SCALE_RESET = CFG_W'(1) << FRAC_BITS;

    // Register map, word index into the configuration space.
    typedef enum logic [IDX_W-1:0] {
        REG_MAP_OFFSET = 2'd0,
        REG_MAP_SCALE  = 2'd1,
        REG_DEGREE     = 2'd2
    } t_reg_idx;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic signed [CFG_W-1:0] map_offset;
        logic signed [CFG_W-1:0] map_scale;
        logic [DEG_W-1:0]        degree;
    } t_cfg;

    // Request to the shared multiplier.
    typedef struct packed {
        logic start;
        logic dbl;
    } t_mul_req;

    // Status from the shared multiplier.
    typedef struct packed {
        logic done;
        logic ovf;
    } t_mul_rsp;

endpackage

// ----- design/chebpe_regs.sv -----
module chebpe_regs import chebpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic signed [CFG_W-1:0] r_offset;
    logic signed [CFG_W-1:0] r_scale;
    logic [DEG_W-1:0]        r_degree;
    logic                    wr_en;
    t_reg_idx                idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);

    // Register writes; an address beyond the map is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_scale  <= SCALE_RESET;
            r_degree <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_MAP_OFFSET: r_offset <= pwdata;
                REG_MAP_SCALE:  r_scale  <= pwdata;
                REG_DEGREE:     r_degree <= pwdata[DEG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (idx)
            REG_MAP_OFFSET: prdata = r_offset;
            REG_MAP_SCALE:  prdata = r_scale;
            REG_DEGREE:     prdata = {{(CFG_W-DEG_W){1'b0}}, r_degree};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.map_offset = r_offset;
    assign o_cfg.map_scale  = r_scale;
    assign o_cfg.degree     = r_degree;

endmodule

// ----- design/chebpe_mul.sv -----
module chebpe_mul import chebpe_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mul_req                i_req,
    input  logic signed [VAL_W-1:0] i_a,
    input  logic signed [VAL_W-1:0] i_b,
    output t_mul_rsp                o_rsp,
    output logic signed [VAL_W-1:0] o_p
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_RND
    } t_state;

    localparam logic [PROD_W-1:0] HALF_SGL = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] HALF_DBL = PROD_W'(1) << (FRAC_BITS - 2);
    localparam logic [VAL_W-1:0]  NEG_LIM  = VAL_W'(1) << (VAL_W - 1);

    t_state                  r_state, n_state;
    logic [1:0]              r_ph, n_ph;
    logic [VAL_W-1:0]        r_ma, n_ma;
    logic [VAL_W-1:0]        r_mb, n_mb;
    logic                    r_neg, n_neg;
    logic                    r_dbl, n_dbl;
    logic [PROD_W-1:0]       r_acc, n_acc;
    logic signed [VAL_W-1:0] r_p, n_p;
    logic                    r_done, n_done;
    logic                    r_ovf, n_ovf;

    logic [HALF_W-1:0]       a_part;
    logic [HALF_W-1:0]       b_part;
    logic [2*HALF_W-1:0]     pp;
    logic [PROD_W-1:0]       pp_sh;
    logic [PROD_W-1:0]       acc_base;
    logic [PROD_W-1:0]       q;
    logic                    q_hi;
    logic [VAL_W-1:0]        qm;

    // One partial product a cycle: low*low, high*low, low*high, high*high.
    assign a_part = r_ph[0] ? r_ma[VAL_W-1:HALF_W] : r_ma[HALF_W-1:0];
    assign b_part = r_ph[1] ? r_mb[VAL_W-1:HALF_W] : r_mb[HALF_W-1:0];
    assign pp     = a_part * b_part;

    always_comb begin
        case (r_ph)
            2'd0:    pp_sh = PROD_W'(pp);
            2'd3:    pp_sh = PROD_W'(pp) << VAL_W;
            default: pp_sh = PROD_W'(pp) << HALF_W;
        endcase
    end

    // The rounding constant seeds the accumulator with the first product.
    assign acc_base = (r_ph == 2'd0) ? (r_dbl ? HALF_DBL : HALF_SGL) : r_acc;

    // Scale down and check the magnitude against the signed range.
    assign q    = r_dbl ? (r_acc >> (FRAC_BITS - 1)) : (r_acc >> FRAC_BITS);
    assign q_hi = |q[PROD_W-1:VAL_W];
    assign qm   = q[VAL_W-1:0];

    // Sequencer and datapath next values.
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_neg   = r_neg;
        n_dbl   = r_dbl;
        n_acc   = r_acc;
        n_p     = r_p;
        n_done  = 1'b0;
        n_ovf   = r_ovf;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_ma    = i_a[VAL_W-1] ? VAL_W'(-i_a) : VAL_W'(i_a);
                    n_mb    = i_b[VAL_W-1] ? VAL_W'(-i_b) : VAL_W'(i_b);
                    n_neg   = i_a[VAL_W-1] ^ i_b[VAL_W-1];
                    n_dbl   = i_req.dbl;
                    n_ph    = 2'd0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc = acc_base + pp_sh;
                n_ph  = r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                n_ovf = 1'b0;
                if (r_neg) begin
                    if (q_hi || (qm > NEG_LIM)) begin
                        n_p   = VAL_MIN;
                        n_ovf = 1'b1;
                    end else begin
                        n_p = -$signed(qm);
                    end
                end else begin
                    if (q_hi || qm[VAL_W-1]) begin
                        n_p   = VAL_MAX;
                        n_ovf = 1'b1;
                    end else begin
                        n_p = $signed(qm);
                    end
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_ph  <= n_ph;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_neg <= n_neg;
        r_dbl <= n_dbl;
        r_acc <= n_acc;
        r_p   <= n_p;
        r_ovf <= n_ovf;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_p        = r_p;

endmodule

// ----- design/chebyshev_poly_eval_mapped.sv -----
// Channel   Handshake                    Word
// input     i_in_valid / o_in_ready      i_sample, i_last_in
// output    o_out_valid / i_out_ready    o_poly_value, o_overflow, o_last_out
// config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A word reaches the output register after the mapping and the recurrence up to degree d,
// d being the degree clamped to MAX_DEGREE; degree zero skips the mapping. The mapping and each
// recurrence step run on one shared 24x24 unit: issue, four partial products, rounding,
// handback, and one saturating add or subtract. o_in_ready is high only while the sequencer
// is idle, so a word is not accepted before the last has left the sequencer; a stalled output
// holds one word in the output register and the next in the sequencer. Reset is synchronous
// and active low; it returns control state, output valid and configuration to their defaults.
module chebyshev_poly_eval_mapped import chebpe_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                    i_last_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_poly_value,
    output logic                    o_overflow,
    output logic                    o_last_out,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [CFG_W-1:0]        pwdata,
    output logic [CFG_W-1:0]        prdata,
    output logic                    pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_MAP_WAIT,
        S_OFFSET,
        S_REC,
        S_REC_WAIT,
        S_SUB,
        S_DONE
    } t_state;

    t_cfg                       cfg;
    t_mul_req                   mul_req;
    t_mul_rsp                   mul_rsp;
    logic signed [VAL_W-1:0]    mul_a;
    logic signed [VAL_W-1:0]    mul_b;
    logic signed [VAL_W-1:0]    mul_p;

    t_state                     r_state, n_state;
    logic signed [SAMPLE_W-1:0] r_x, n_x;
    logic                       r_last, n_last;
    logic [CNT_W-1:0]           r_deg, n_deg;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic signed [VAL_W-1:0]    r_y, n_y;
    logic signed [VAL_W-1:0]    r_tcur, n_tcur;
    logic signed [VAL_W-1:0]    r_tprev, n_tprev;
    logic                       r_ov, n_ov;
    logic                       r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0]    r_out_val, n_out_val;
    logic                       r_out_ov, n_out_ov;
    logic                       r_out_last, n_out_last;

    logic [DEG_W:0]             deg_ext;
    logic [CNT_W-1:0]           deg_clamp;
    logic signed [VAL_W:0]      sum_off;
    logic signed [VAL_W:0]      diff_rec;
    logic                       sum_ovf;
    logic                       diff_ovf;
    logic signed [VAL_W-1:0]    sum_sat;
    logic signed [VAL_W-1:0]    diff_sat;

    chebpe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    chebpe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_rsp   (mul_rsp),
        .o_p     (mul_p)
    );

    // Clamp the programmed degree to the supported maximum.
    assign deg_ext   = {1'b0, cfg.degree};
    assign deg_clamp = (deg_ext > (DEG_W+1)'(MAX_DEGREE)) ? CNT_W'(MAX_DEGREE)
                                                          : CNT_W'(deg_ext);

    // Multiplier operands: the affine scale first, then y times the current term.
    assign mul_req.start = (r_state == S_MAP) || (r_state == S_REC);
    assign mul_req.dbl   = (r_state == S_REC);
    assign mul_a = (r_state == S_REC) ? r_y : VAL_W'($signed(cfg.map_scale));
    assign mul_b = (r_state == S_REC) ? r_tcur : VAL_W'(r_x);

    // Saturating add of the offset and saturating subtract of the older term.
    assign sum_off  = {mul_p[VAL_W-1], mul_p} + (VAL_W+1)'($signed(cfg.map_offset));
    assign diff_rec = {mul_p[VAL_W-1], mul_p} - {r_tprev[VAL_W-1], r_tprev};
    assign sum_ovf  = sum_off[VAL_W] ^ sum_off[VAL_W-1];
    assign diff_ovf = diff_rec[VAL_W] ^ diff_rec[VAL_W-1];
    assign sum_sat  = sum_ovf ? (sum_off[VAL_W] ? VAL_MIN : VAL_MAX)
                              : sum_off[VAL_W-1:0];
    assign diff_sat = diff_ovf ? (diff_rec[VAL_W] ? VAL_MIN : VAL_MAX)
                               : diff_rec[VAL_W-1:0];

    // Sequencer: map the sample, then run the recurrence up to the degree.
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_last      = r_last;
        n_deg       = r_deg;
        n_cnt       = r_cnt;
        n_y         = r_y;
        n_tcur      = r_tcur;
        n_tprev     = r_tprev;
        n_ov        = r_ov;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out_val   = r_out_val;
        n_out_ov    = r_out_ov;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = i_sample;
                    n_last  = i_last_in;
                    n_deg   = deg_clamp;
                    n_tcur  = VAL_ONE;
                    n_ov    = 1'b0;
                    n_state = (deg_clamp == '0) ? S_DONE : S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_MAP_WAIT;
            end
            S_MAP_WAIT: begin
                if (mul_rsp.done) begin
                    n_ov    = r_ov | mul_rsp.ovf;
                    n_state = S_OFFSET;
                end
            end
            S_OFFSET: begin
                n_y     = sum_sat;
                n_tcur  = sum_sat;
                n_tprev = VAL_ONE;
                n_ov    = r_ov | sum_ovf;
                n_cnt   = CNT_W'(2);
                n_state = (r_deg == CNT_W'(1)) ? S_DONE : S_REC;
            end
            S_REC: begin
                n_state = S_REC_WAIT;
            end
            S_REC_WAIT: begin
                if (mul_rsp.done) begin
                    n_ov    = r_ov | mul_rsp.ovf;
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                n_tprev = r_tcur;
                n_tcur  = diff_sat;
                n_ov    = r_ov | diff_ovf;
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = (r_cnt == r_deg) ? S_DONE : S_REC;
            end
            S_DONE: begin
                // Hand the word to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_tcur;
                    n_out_ov    = r_ov;
                    n_out_last  = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_x        <= n_x;
        r_last     <= n_last;
        r_deg      <= n_deg;
        r_cnt      <= n_cnt;
        r_y        <= n_y;
        r_tcur     <= n_tcur;
        r_tprev    <= n_tprev;
        r_ov       <= n_ov;
        r_out_val  <= n_out_val;
        r_out_ov   <= n_out_ov;
        r_out_last <= n_out_last;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_poly_value = r_out_val;
    assign o_overflow   = r_out_ov;
    assign o_last_out   = r_out_last;

endmodule
